FILE: hdl/mlr_pkg.sv
`default_nettype none
package mlr_pkg;

   localparam int COEF_W = 23;
   localparam int OP_W = 2;
   localparam int HIGH_W = 10;
   localparam int LOW_W = 14;

   localparam logic [COEF_W-1:0] Q_MOD = COEF_W'(8380417);

   // power2round
   localparam int DROPPED_BITS = 13;
   localparam int P2R_W = COEF_W + 1;
   localparam logic [P2R_W-1:0] P2R_FULL = P2R_W'(1) << DROPPED_BITS;
   localparam logic [P2R_W-1:0] P2R_HALF = P2R_W'(1) << (DROPPED_BITS - 1);
   localparam logic [P2R_W-1:0] P2R_MASK = P2R_FULL - P2R_W'(1);

   // decompose: 2*gamma2 = 93 * 2^11 (m = 44) or 1023 * 2^9 (m = 16)
   localparam int QUOT_W = 6;
   localparam int REM_W = 20;
   localparam int PROD_W = QUOT_W + REM_W;
   localparam logic [REM_W-1:0] TWO_G_88 = REM_W'(190464);
   localparam logic [REM_W-1:0] TWO_G_32 = REM_W'(523776);
   localparam logic [REM_W-1:0] GAMMA2_88 = REM_W'(95232);
   localparam logic [REM_W-1:0] GAMMA2_32 = REM_W'(261888);
   localparam logic [QUOT_W-1:0] M_88 = QUOT_W'(44);
   localparam logic [QUOT_W-1:0] M_32 = QUOT_W'(16);

   // quotient estimate for m = 44: ((r >> 11) * 11) >> 10, never above the floor
   localparam int EST_IN_SHIFT_88 = 11;
   localparam int EST_X_W = COEF_W - EST_IN_SHIFT_88;
   localparam int EST_MUL_W = EST_X_W + 4;
   localparam logic [EST_MUL_W-1:0] EST_MUL_88 = EST_MUL_W'(11);
   localparam int EST_OUT_SHIFT_88 = 10;
   // estimate for m = 16: r >> 19
   localparam int EST_SHIFT_32 = 19;

   localparam logic [OP_W-1:0] OP_POWER2ROUND = OP_W'(0);
   localparam logic [OP_W-1:0] OP_HIGH_BITS = OP_W'(1);
   localparam logic [OP_W-1:0] OP_USE_HINT = OP_W'(2);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COEF_W-1:0] coef;
      logic              hint;
   } item_type;

endpackage
`default_nettype wire

FILE: hdl/mlr_front.sv
`default_nettype none
module mlr_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [mlr_pkg::OP_W-1:0]     req_operation,
   input  wire logic [mlr_pkg::COEF_W-1:0]   req_coefficient,
   input  wire logic                         req_hint,
   output logic                              push_valid,
   input  wire logic                         push_ready,
   output mlr_pkg::item_type                 push_item
);

   logic              valid_ff;
   logic              valid_in;
   mlr_pkg::item_type item_ff;
   mlr_pkg::item_type item_in;
   logic              take;

   assign req_ready = !valid_ff || push_ready;
   assign take = req_valid && req_ready;

   always_comb begin
      item_in.op = req_operation;
      item_in.hint = req_hint;
      // one subtraction reduces any 23-bit pattern
      if (req_coefficient >= mlr_pkg::Q_MOD) begin
         item_in.coef = req_coefficient - mlr_pkg::Q_MOD;
      end else begin
         item_in.coef = req_coefficient;
      end
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item = item_ff;

endmodule
`default_nettype wire

FILE: hdl/mlr_queue.sv
`default_nettype none
module mlr_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire mlr_pkg::item_type push_item,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output mlr_pkg::item_type pop_item
);

   mlr_pkg::item_type               mem_ff [mlr_pkg::QUEUE_DEPTH];
   logic [mlr_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [mlr_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [mlr_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [mlr_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [mlr_pkg::QCNT_W-1:0]      count_ff;
   logic [mlr_pkg::QCNT_W-1:0]      count_in;
   logic                            do_push;
   logic                            do_pop;

   assign push_ready = count_ff != mlr_pkg::QCNT_W'(mlr_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == mlr_pkg::QPTR_W'(mlr_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + mlr_pkg::QPTR_W'(1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == mlr_pkg::QPTR_W'(mlr_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + mlr_pkg::QPTR_W'(1);
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + mlr_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - mlr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/mlr_back.sv
`default_nettype none
module mlr_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               gamma_mode,
   input  wire logic                               pop_valid,
   output logic                                    pop_ready,
   input  wire mlr_pkg::item_type                  pop_item,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [mlr_pkg::HIGH_W-1:0]              rsp_high_part,
   output logic signed [mlr_pkg::LOW_W-1:0]        rsp_low_part
);

   typedef struct packed {
      mlr_pkg::item_type          item;
      logic [mlr_pkg::QUOT_W-1:0] quot;
   } est_type;

   typedef struct packed {
      mlr_pkg::item_type          item;
      logic [mlr_pkg::QUOT_W-1:0] quot;
      logic [mlr_pkg::REM_W-1:0]  rem;
   } div_type;

   logic                             advance;
   logic                             s1_valid_ff;
   logic                             s2_valid_ff;
   logic                             out_valid_ff;
   est_type                          s1_ff;
   est_type                          s1_in;
   div_type                          s2_ff;
   div_type                          s2_in;
   logic [mlr_pkg::HIGH_W-1:0]       high_ff;
   logic [mlr_pkg::HIGH_W-1:0]       high_in;
   logic [mlr_pkg::LOW_W-1:0]        low_ff;
   logic [mlr_pkg::LOW_W-1:0]        low_in;

   logic [mlr_pkg::REM_W-1:0]        two_g;
   logic [mlr_pkg::REM_W-1:0]        gamma2;
   logic [mlr_pkg::QUOT_W-1:0]       m_val;
   logic [mlr_pkg::EST_MUL_W-1:0]    est_prod;
   logic [mlr_pkg::PROD_W-1:0]       back_prod;
   logic [mlr_pkg::PROD_W-1:0]       diff;
   logic [mlr_pkg::REM_W-1:0]        rem_raw;
   logic [mlr_pkg::QUOT_W-1:0]       r1_pre;
   logic [mlr_pkg::QUOT_W-1:0]       r1;
   logic [mlr_pkg::QUOT_W:0]         r1_sum;
   logic                             r0_pos;
   logic [mlr_pkg::P2R_W-1:0]        p2r_low;
   logic [mlr_pkg::P2R_W-1:0]        p2r_low_c;
   logic [mlr_pkg::P2R_W-1:0]        p2r_high;

   assign advance = !out_valid_ff || rsp_ready;
   assign pop_ready = advance;

   always_comb begin
      if (gamma_mode) begin
         two_g = mlr_pkg::TWO_G_32;
         gamma2 = mlr_pkg::GAMMA2_32;
         m_val = mlr_pkg::M_32;
      end else begin
         two_g = mlr_pkg::TWO_G_88;
         gamma2 = mlr_pkg::GAMMA2_88;
         m_val = mlr_pkg::M_88;
      end
   end

   // quotient estimate, floor or floor minus one
   always_comb begin
      est_prod = mlr_pkg::EST_MUL_W'(pop_item.coef >> mlr_pkg::EST_IN_SHIFT_88)
                 * mlr_pkg::EST_MUL_88;
      s1_in.item = pop_item;
      if (gamma_mode) begin
         s1_in.quot = mlr_pkg::QUOT_W'(pop_item.coef >> mlr_pkg::EST_SHIFT_32);
      end else begin
         s1_in.quot = mlr_pkg::QUOT_W'(est_prod >> mlr_pkg::EST_OUT_SHIFT_88);
      end
   end

   // remainder with one correction step
   always_comb begin
      back_prod = mlr_pkg::PROD_W'(s1_ff.quot) * mlr_pkg::PROD_W'(two_g);
      diff = mlr_pkg::PROD_W'(s1_ff.item.coef) - back_prod;
      rem_raw = diff[mlr_pkg::REM_W-1:0];
      s2_in.item = s1_ff.item;
      if (rem_raw >= two_g) begin
         s2_in.quot = s1_ff.quot + mlr_pkg::QUOT_W'(1);
         s2_in.rem = rem_raw - two_g;
      end else begin
         s2_in.quot = s1_ff.quot;
         s2_in.rem = rem_raw;
      end
   end

   // decompose, hint, power2round and result select
   always_comb begin
      if (s2_ff.rem > gamma2) begin
         r1_pre = s2_ff.quot + mlr_pkg::QUOT_W'(1);
      end else begin
         r1_pre = s2_ff.quot;
      end
      // top end of the range wraps to zero
      if (r1_pre == m_val) begin
         r1 = '0;
      end else begin
         r1 = r1_pre;
      end
      r0_pos = (s2_ff.rem != '0) && (s2_ff.rem <= gamma2);
      if (r0_pos) begin
         r1_sum = {1'b0, r1} + (mlr_pkg::QUOT_W + 1)'(1);
      end else begin
         r1_sum = {1'b0, r1} + {1'b0, m_val} - (mlr_pkg::QUOT_W + 1)'(1);
      end
      if (r1_sum >= {1'b0, m_val}) begin
         r1_sum = r1_sum - {1'b0, m_val};
      end

      p2r_low = mlr_pkg::P2R_W'(s2_ff.item.coef) & mlr_pkg::P2R_MASK;
      p2r_high = mlr_pkg::P2R_W'(s2_ff.item.coef >> mlr_pkg::DROPPED_BITS);
      if (p2r_low > mlr_pkg::P2R_HALF) begin
         p2r_low_c = p2r_low - mlr_pkg::P2R_FULL;
         p2r_high = p2r_high + mlr_pkg::P2R_W'(1);
      end else begin
         p2r_low_c = p2r_low;
      end

      unique case (s2_ff.item.op) inside
         mlr_pkg::OP_POWER2ROUND: begin
            high_in = p2r_high[mlr_pkg::HIGH_W-1:0];
            low_in = p2r_low_c[mlr_pkg::LOW_W-1:0];
         end
         mlr_pkg::OP_HIGH_BITS, mlr_pkg::OP_USE_HINT: begin
            if (s2_ff.item.op == mlr_pkg::OP_USE_HINT && s2_ff.item.hint) begin
               high_in = mlr_pkg::HIGH_W'(r1_sum);
            end else begin
               high_in = mlr_pkg::HIGH_W'(r1);
            end
            low_in = '0;
         end
         default: begin
            high_in = '0;
            low_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop_valid;
         s2_valid_ff <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         high_ff <= high_in;
         low_ff <= low_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_high_part = high_ff;
   assign rsp_low_part = $signed(low_ff);

endmodule
`default_nettype wire

FILE: hdl/ml_dsa_coefficient_rounding.sv
// channel   direction  ports
// req       in         req_valid, req_ready, req_operation, req_coefficient, req_hint
// rsp       out        rsp_valid, rsp_ready, rsp_high_part, rsp_low_part
// csr       in         csr_valid, csr_ready, csr_gamma_mode
//
// one item per cycle sustained while rsp_ready stays high; a result passes in order through
// the input register, 2-entry queue, estimate, remainder and output stages
// synchronous reset clears all valid flags and sets gamma_mode to 0
// a stalled rsp side holds the back pipeline; req stays open until the queue and
// the input register hold 3 items
// csr writes are always taken
`default_nettype none
module ml_dsa_coefficient_rounding (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [mlr_pkg::OP_W-1:0]           req_operation,
   input  wire logic [mlr_pkg::COEF_W-1:0]         req_coefficient,
   input  wire logic                               req_hint,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [mlr_pkg::HIGH_W-1:0]              rsp_high_part,
   output logic signed [mlr_pkg::LOW_W-1:0]        rsp_low_part,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic                               csr_gamma_mode
);

   logic              gamma_mode_ff;
   logic              front_valid;
   logic              front_ready;
   mlr_pkg::item_type front_item;
   logic              queue_valid;
   logic              queue_ready;
   mlr_pkg::item_type queue_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         gamma_mode_ff <= csr_gamma_mode;
      end
   end

   mlr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_coefficient (req_coefficient),
      .req_hint        (req_hint),
      .push_valid      (front_valid),
      .push_ready      (front_ready),
      .push_item       (front_item)
   );

   mlr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   mlr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .gamma_mode    (gamma_mode_ff),
      .pop_valid     (queue_valid),
      .pop_ready     (queue_ready),
      .pop_item      (queue_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_high_part (rsp_high_part),
      .rsp_low_part  (rsp_low_part)
   );

endmodule
`default_nettype wire
